/* sv/csd_pkg.sv */
`timescale 1ns / 1ps
package csd_pkg;

  localparam int MAX_SAMPLES_DEF = 1024;

  // Default quiet NaN produced by invalid operations, and the quiet bit of a NaN.
  localparam logic [63:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
  localparam logic [63:0] QUIET_BIT   = 64'h0008_0000_0000_0000;

  typedef struct packed {
    logic [63:0] sample_bits;
    logic        is_last;
  } sample_t;

  typedef struct packed {
    logic [63:0] deviation_bits;
    logic        dropped;
  } result_t;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_SQRT,
    OP_MOV
  } fpu_op_t;

  typedef struct packed {
    logic        start;
    fpu_op_t     op;
    logic [63:0] a;
    logic [63:0] b;
  } fpu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } fpu_rsp_t;

endpackage

/* sv/csd_fpu.sv */
`timescale 1ns / 1ps
module csd_fpu (
  input  logic              clk,
  input  logic              rst,
  input  csd_pkg::fpu_req_t req,
  output csd_pkg::fpu_rsp_t rsp
);

  typedef enum logic [3:0] {
    F_IDLE, F_PRENORM, F_ALIGN, F_MUL, F_DIV, F_SQRT, F_NORM, F_ROUND, F_DONE
  } fstate_t;

  fstate_t                state;
  csd_pkg::fpu_op_t       op;
  logic                   sa, sb, rs;
  logic signed [13:0]     ea, eb, ex;
  logic [52:0]            ma, mb;
  logic [56:0]            w;
  logic [105:0]           acc;
  logic [54:0]            rem;
  logic [55:0]            quo;
  logic [107:0]           rad;
  logic [55:0]            sr;
  logic [53:0]            sq;
  logic [5:0]             cnt;
  logic [63:0]            res;

  // Shift right, folding every bit shifted out into the lowest bit.
  function automatic logic [56:0] shr_sticky(input logic [56:0] x, input logic [6:0] s);
    logic [56:0] mask;
    mask = ~({57{1'b1}} << s);
    shr_sticky = (x >> s) | {56'd0, |(x & mask)};
  endfunction

  // Operand classification at the start of an operation.
  logic [10:0] fa, fb;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, b_sgn, spec;
  logic [63:0] sres;

  assign fa     = req.a[62:52];
  assign fb     = req.b[62:52];
  assign a_nan  = (fa == 11'h7FF) && (req.a[51:0] != 52'd0);
  assign b_nan  = (fb == 11'h7FF) && (req.b[51:0] != 52'd0);
  assign a_inf  = (fa == 11'h7FF) && (req.a[51:0] == 52'd0);
  assign b_inf  = (fb == 11'h7FF) && (req.b[51:0] == 52'd0);
  assign a_zero = (req.a[62:0] == 63'd0);
  assign b_zero = (req.b[62:0] == 63'd0);
  assign b_sgn  = req.b[63] ^ (req.op == csd_pkg::OP_SUB);

  always_comb begin
    spec = 1'b1;
    sres = '0;
    case (req.op)
      csd_pkg::OP_ADD, csd_pkg::OP_SUB: begin
        if (a_nan) sres = req.a | csd_pkg::QUIET_BIT;
        else if (b_nan) sres = req.b | csd_pkg::QUIET_BIT;
        else if (a_inf && b_inf && (req.a[63] != b_sgn)) sres = csd_pkg::DEFAULT_NAN;
        else if (a_inf) sres = req.a;
        else if (b_inf) sres = {b_sgn, req.b[62:0]};
        else if (a_zero && b_zero) sres = {req.a[63] & b_sgn, 63'd0};
        else if (a_zero) sres = {b_sgn, req.b[62:0]};
        else if (b_zero) sres = req.a;
        else spec = 1'b0;
      end
      csd_pkg::OP_MUL: begin
        if (a_nan) sres = req.a | csd_pkg::QUIET_BIT;
        else if (b_nan) sres = req.b | csd_pkg::QUIET_BIT;
        else if ((a_inf && b_zero) || (a_zero && b_inf)) sres = csd_pkg::DEFAULT_NAN;
        else if (a_inf || b_inf) sres = {req.a[63] ^ req.b[63], 11'h7FF, 52'd0};
        else if (a_zero || b_zero) sres = {req.a[63] ^ req.b[63], 63'd0};
        else spec = 1'b0;
      end
      csd_pkg::OP_DIV: begin
        if (a_nan) sres = req.a | csd_pkg::QUIET_BIT;
        else if (b_nan) sres = req.b | csd_pkg::QUIET_BIT;
        else if ((a_inf && b_inf) || (a_zero && b_zero)) sres = csd_pkg::DEFAULT_NAN;
        else if (a_inf || b_zero) sres = {req.a[63] ^ req.b[63], 11'h7FF, 52'd0};
        else if (a_zero || b_inf) sres = {req.a[63] ^ req.b[63], 63'd0};
        else spec = 1'b0;
      end
      csd_pkg::OP_SQRT: begin
        if (a_nan) sres = req.a | csd_pkg::QUIET_BIT;
        else if (a_inf) sres = req.a[63] ? csd_pkg::DEFAULT_NAN : req.a;
        else if (a_zero) sres = req.a;
        else if (req.a[63]) sres = csd_pkg::DEFAULT_NAN;
        else spec = 1'b0;
      end
      default: sres = req.a;
    endcase
  end

  // Alignment and add of two finite nonzero operands.
  logic               a_big;
  logic signed [13:0] e_l, e_s, e_d;
  logic [52:0]        m_l, m_s;
  logic [6:0]         d_sh;
  logic [56:0]        w_l, w_s, w_sum;

  always_comb begin
    a_big = {ea, ma} >= {eb, mb};
    e_l   = a_big ? ea : eb;
    e_s   = a_big ? eb : ea;
    m_l   = a_big ? ma : mb;
    m_s   = a_big ? mb : ma;
    e_d   = e_l - e_s;
    d_sh  = (e_d > 14'sd127) ? 7'd127 : e_d[6:0];
    w_l   = {1'b0, m_l, 3'b000};
    w_s   = shr_sticky({1'b0, m_s, 3'b000}, d_sh);
    w_sum = (sa ^ sb) ? (w_l - w_s) : (w_l + w_s);
  end

  // One 27 by 27 partial product per cycle.
  logic [26:0]  pa, pb;
  logic [53:0]  pp;
  logic [105:0] pp_sh, acc_sum;

  always_comb begin
    pa = cnt[1] ? {1'b0, ma[52:27]} : ma[26:0];
    pb = cnt[0] ? {1'b0, mb[52:27]} : mb[26:0];
    pp = 54'(pa) * 54'(pb);
    if (cnt[1] & cnt[0]) pp_sh = 106'(pp) << 54;
    else if (cnt[1] | cnt[0]) pp_sh = 106'(pp) << 27;
    else pp_sh = 106'(pp);
    acc_sum = acc + pp_sh;
  end

  // Restoring division, one quotient bit per cycle.
  logic        d_ge;
  logic [54:0] rem_d;
  logic [55:0] quo_n;

  always_comb begin
    d_ge  = rem >= {2'b00, mb};
    rem_d = d_ge ? (rem - {2'b00, mb}) : rem;
    quo_n = {quo[54:0], d_ge};
  end

  // Digit-by-digit square root, one result bit per cycle.
  logic [57:0]        r_cat, t_sq, sr_n;
  logic               s_ge;
  logic [53:0]        sq_n, q_rnd;
  logic signed [13:0] e_half, big;

  always_comb begin
    r_cat  = {sr, rad[107:106]};
    t_sq   = {2'b00, sq, 2'b01};
    s_ge   = r_cat >= t_sq;
    sr_n   = s_ge ? (r_cat - t_sq) : r_cat;
    sq_n   = {sq[52:0], s_ge};
    q_rnd  = {1'b0, sq_n[53:1]} + 54'(sq_n[0]);
    e_half = (ex - 14'sd54) >>> 1;
    big    = e_half + 14'sd1 + (q_rnd[53] ? 14'sd1 : 14'sd0);
  end

  // Rounding to nearest even, with gradual underflow and overflow to infinity.
  logic signed [13:0] sh_s;
  logic [6:0]         sh;
  logic [56:0]        w_d;
  logic [62:0]        base;
  logic               inc;
  logic [63:0]        rnd_res;

  always_comb begin
    sh_s    = 14'sd1 - ex;
    if (ex >= 14'sd1) sh = 7'd0;
    else if (sh_s > 14'sd63) sh = 7'd63;
    else sh = sh_s[6:0];
    w_d     = shr_sticky(w, sh);
    base    = (ex >= 14'sd1) ? {ex[10:0], w_d[54:3]} : {11'd0, w_d[54:3]};
    inc     = w_d[2] & (w_d[1] | w_d[0] | w_d[3]);
    rnd_res = (ex >= 14'sd2047) ? {rs, 11'h7FF, 52'd0} : {rs, base + 63'(inc)};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (req.start) begin
            op <= req.op;
            sa <= req.a[63];
            sb <= b_sgn;
            ea <= (fa == 11'd0) ? 14'sd1 : {3'b000, fa};
            eb <= (fb == 11'd0) ? 14'sd1 : {3'b000, fb};
            ma <= {fa != 11'd0, req.a[51:0]};
            mb <= {fb != 11'd0, req.b[51:0]};
            if (spec) begin
              res   <= sres;
              state <= F_DONE;
            end else if (req.op == csd_pkg::OP_ADD || req.op == csd_pkg::OP_SUB) begin
              state <= F_ALIGN;
            end else begin
              state <= F_PRENORM;
            end
          end
        end
        F_PRENORM: begin
          if (!ma[52]) begin
            if (ma[52:37] == 16'd0) begin
              ma <= ma << 16;
              ea <= ea - 14'sd16;
            end else if (ma[52:49] == 4'd0) begin
              ma <= ma << 4;
              ea <= ea - 14'sd4;
            end else begin
              ma <= ma << 1;
              ea <= ea - 14'sd1;
            end
          end
          if (!mb[52]) begin
            if (mb[52:37] == 16'd0) begin
              mb <= mb << 16;
              eb <= eb - 14'sd16;
            end else if (mb[52:49] == 4'd0) begin
              mb <= mb << 4;
              eb <= eb - 14'sd4;
            end else begin
              mb <= mb << 1;
              eb <= eb - 14'sd1;
            end
          end
          if (ma[52] && (mb[52] || op == csd_pkg::OP_SQRT)) begin
            cnt <= '0;
            case (op)
              csd_pkg::OP_MUL: begin
                acc   <= '0;
                state <= F_MUL;
              end
              csd_pkg::OP_DIV: begin
                rem   <= {2'b00, ma};
                quo   <= '0;
                state <= F_DIV;
              end
              default: begin
                // Even exponent: an odd one moves a bit into the radicand.
                if (ea[0]) begin
                  rad <= {1'b0, ma, 54'd0};
                  ex  <= ea - 14'sd1075;
                end else begin
                  rad <= {ma, 1'b0, 54'd0};
                  ex  <= ea - 14'sd1076;
                end
                sr    <= '0;
                sq    <= '0;
                state <= F_SQRT;
              end
            endcase
          end
        end
        F_ALIGN: begin
          if (w_sum == 57'd0) begin
            res   <= '0;
            state <= F_DONE;
          end else begin
            w     <= w_sum;
            ex    <= e_l;
            rs    <= a_big ? sa : sb;
            state <= F_NORM;
          end
        end
        F_MUL: begin
          acc <= acc_sum;
          cnt <= cnt + 6'd1;
          if (cnt == 6'd3) begin
            w     <= acc_sum[105:49] | {56'd0, |acc_sum[48:0]};
            ex    <= ea + eb - 14'sd1023;
            rs    <= sa ^ sb;
            state <= F_NORM;
          end
        end
        F_DIV: begin
          quo <= quo_n;
          rem <= {rem_d[53:0], 1'b0};
          cnt <= cnt + 6'd1;
          if (cnt == 6'd55) begin
            w     <= {1'b0, quo_n} | {56'd0, rem_d != 55'd0};
            ex    <= ea - eb + 14'sd1023;
            rs    <= sa ^ sb;
            state <= F_NORM;
          end
        end
        F_SQRT: begin
          rad <= rad << 2;
          sr  <= sr_n[55:0];
          sq  <= sq_n;
          cnt <= cnt + 6'd1;
          if (cnt == 6'd53) begin
            res   <= {1'b0, 11'(big + 14'sd1075), q_rnd[51:0]};
            state <= F_DONE;
          end
        end
        F_NORM: begin
          if (w[56]) begin
            w  <= {1'b0, w[56:2], w[1] | w[0]};
            ex <= ex + 14'sd1;
          end else if (w[55]) begin
            state <= F_ROUND;
          end else if (w[55:40] == 16'd0) begin
            w  <= w << 16;
            ex <= ex - 14'sd16;
          end else if (w[55:52] == 4'd0) begin
            w  <= w << 4;
            ex <= ex - 14'sd4;
          end else begin
            w  <= w << 1;
            ex <= ex - 14'sd1;
          end
        end
        F_ROUND: begin
          res   <= rnd_res;
          state <= F_DONE;
        end
        F_DONE: begin
          state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  assign rsp.done = (state == F_DONE);
  assign rsp.res  = res;

endmodule

/* sv/compensated_std_deviation.sv */
`timescale 1ns / 1ps
// Channel   Direction  Word        Handshake
// sample    in         sample_t    sample_valid / sample_ready
// result    out        result_t    result_valid / result_ready
//
// A word marked last starts the computation, which runs two passes over the
// stored set through one shared floating-point unit. Besides the two passes,
// the program performs three divisions, a square, a subtraction and the root.
// Reset clears the sample count, the drop flag and the output valid; the
// sample memory itself is not cleared. sample_ready is low while a set is
// being computed; a finished result waits in the output register while the
// next set loads, and the block only stalls if a second result is ready first.
module compensated_std_deviation #(
  parameter int MAX_SAMPLES = csd_pkg::MAX_SAMPLES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_ready,
  input  csd_pkg::sample_t sample,
  output logic             result_valid,
  input  logic             result_ready,
  output csd_pkg::result_t result
);

  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int CW = $clog2(MAX_SAMPLES + 1);

  // Working registers of the micro-program.
  typedef enum logic [3:0] {
    R_X, R_HI, R_LO, R_A, R_T, R_TMP, R_MEAN, R_S, R_SL, R_SQ, R_SQL, R_DIFF, R_ND, R_NM1
  } reg_id_t;

  typedef struct packed {
    csd_pkg::fpu_op_t op;
    reg_id_t          src_a;
    reg_id_t          src_b;
    reg_id_t          dst;
  } uop_t;

  // Program addresses where loops close or phases change.
  localparam logic [4:0] PC_P1_START = 5'd0;
  localparam logic [4:0] PC_P1_END   = 5'd4;
  localparam logic [4:0] PC_MEAN     = 5'd5;
  localparam logic [4:0] PC_P2_START = 5'd6;
  localparam logic [4:0] PC_P2_END   = 5'd17;
  localparam logic [4:0] PC_FIN      = 5'd18;
  localparam logic [4:0] PC_LAST     = 5'd22;

  // First pass: compensated sum. Second pass: compensated sums of deviations
  // and of their squares. Then the variance and its root.
  function automatic uop_t prog(input logic [4:0] pc_in);
    case (pc_in)
      5'd0:    prog = '{csd_pkg::OP_ADD,  R_X,    R_LO,   R_A};
      5'd1:    prog = '{csd_pkg::OP_ADD,  R_HI,   R_A,    R_T};
      5'd2:    prog = '{csd_pkg::OP_SUB,  R_T,    R_HI,   R_TMP};
      5'd3:    prog = '{csd_pkg::OP_SUB,  R_A,    R_TMP,  R_LO};
      5'd4:    prog = '{csd_pkg::OP_MOV,  R_T,    R_T,    R_HI};
      5'd5:    prog = '{csd_pkg::OP_DIV,  R_HI,   R_ND,   R_MEAN};
      5'd6:    prog = '{csd_pkg::OP_SUB,  R_X,    R_MEAN, R_DIFF};
      5'd7:    prog = '{csd_pkg::OP_ADD,  R_DIFF, R_SL,   R_A};
      5'd8:    prog = '{csd_pkg::OP_ADD,  R_S,    R_A,    R_T};
      5'd9:    prog = '{csd_pkg::OP_SUB,  R_T,    R_S,    R_TMP};
      5'd10:   prog = '{csd_pkg::OP_SUB,  R_A,    R_TMP,  R_SL};
      5'd11:   prog = '{csd_pkg::OP_MOV,  R_T,    R_T,    R_S};
      5'd12:   prog = '{csd_pkg::OP_MUL,  R_DIFF, R_DIFF, R_A};
      5'd13:   prog = '{csd_pkg::OP_ADD,  R_A,    R_SQL,  R_A};
      5'd14:   prog = '{csd_pkg::OP_ADD,  R_SQ,   R_A,    R_T};
      5'd15:   prog = '{csd_pkg::OP_SUB,  R_T,    R_SQ,   R_TMP};
      5'd16:   prog = '{csd_pkg::OP_SUB,  R_A,    R_TMP,  R_SQL};
      5'd17:   prog = '{csd_pkg::OP_MOV,  R_T,    R_T,    R_SQ};
      5'd18:   prog = '{csd_pkg::OP_MUL,  R_S,    R_S,    R_A};
      5'd19:   prog = '{csd_pkg::OP_DIV,  R_A,    R_ND,   R_A};
      5'd20:   prog = '{csd_pkg::OP_SUB,  R_SQ,   R_A,    R_A};
      5'd21:   prog = '{csd_pkg::OP_DIV,  R_A,    R_NM1,  R_A};
      5'd22:   prog = '{csd_pkg::OP_SQRT, R_A,    R_A,    R_A};
      default: prog = '{csd_pkg::OP_MOV,  R_A,    R_A,    R_A};
    endcase
  endfunction

  // Exact conversion of a small count to a double.
  function automatic logic [63:0] int_to_dbl(input logic [31:0] v);
    logic [4:0]  msb;
    logic [63:0] m;
    msb = '0;
    for (int k = 0; k < 32; k++) begin
      if (v[k]) msb = 5'(k);
    end
    m = 64'(v) << (6'd52 - 6'(msb));
    int_to_dbl = (v == 32'd0) ? 64'd0 : {1'b0, 11'd1023 + 11'(msb), m[51:0]};
  endfunction

  typedef enum logic [2:0] {S_LOAD, S_READ, S_CAPTURE, S_ISSUE, S_WAIT, S_DONE} state_t;

  state_t            state;
  logic [CW-1:0]     count, count_next, n_reg, idx;
  logic              ovf, ovf_next, drop_reg, room;
  logic [4:0]        pc;
  logic [63:0]       r_x, r_hi, r_lo, r_a, r_t, r_tmp, r_mean;
  logic [63:0]       r_s, r_sl, r_sq, r_sql, r_diff, r_nd, r_nm1;
  logic [63:0]       opa, opb, wb_data, rdata;
  logic [63:0]       mem [MAX_SAMPLES];
  uop_t              u;
  csd_pkg::fpu_req_t fpu_req;
  csd_pkg::fpu_rsp_t fpu_rsp;
  logic              accept;

  state_t            adv_state;
  logic [4:0]        adv_pc;
  logic [CW-1:0]     adv_idx;

  assign sample_ready = (state == S_LOAD);
  assign accept       = sample_valid && sample_ready;
  assign room         = count < CW'(MAX_SAMPLES);
  assign count_next   = room ? (count + CW'(1)) : count;
  assign ovf_next     = ovf | ~room;
  assign u            = prog(pc);

  function automatic logic [63:0] pick(input reg_id_t id, input logic [63:0] x,
                                       input logic [63:0] hi, input logic [63:0] lo,
                                       input logic [63:0] a, input logic [63:0] t,
                                       input logic [63:0] tmp, input logic [63:0] mean,
                                       input logic [63:0] s, input logic [63:0] sl,
                                       input logic [63:0] sq, input logic [63:0] sql,
                                       input logic [63:0] diff, input logic [63:0] nd,
                                       input logic [63:0] nm1);
    case (id)
      R_X:     pick = x;
      R_HI:    pick = hi;
      R_LO:    pick = lo;
      R_A:     pick = a;
      R_T:     pick = t;
      R_TMP:   pick = tmp;
      R_MEAN:  pick = mean;
      R_S:     pick = s;
      R_SL:    pick = sl;
      R_SQ:    pick = sq;
      R_SQL:   pick = sql;
      R_DIFF:  pick = diff;
      R_ND:    pick = nd;
      R_NM1:   pick = nm1;
      default: pick = a;
    endcase
  endfunction

  assign opa = pick(u.src_a, r_x, r_hi, r_lo, r_a, r_t, r_tmp, r_mean,
                    r_s, r_sl, r_sq, r_sql, r_diff, r_nd, r_nm1);
  assign opb = pick(u.src_b, r_x, r_hi, r_lo, r_a, r_t, r_tmp, r_mean,
                    r_s, r_sl, r_sq, r_sql, r_diff, r_nd, r_nm1);

  // A copy finishes at issue; every other step waits for the unit.
  assign wb_data = (state == S_WAIT) ? fpu_rsp.res : opa;

  assign fpu_req.start = (state == S_ISSUE) && (u.op != csd_pkg::OP_MOV);
  assign fpu_req.op    = u.op;
  assign fpu_req.a     = opa;
  assign fpu_req.b     = opb;

  csd_fpu u_fpu (
    .clk (clk),
    .rst (rst),
    .req (fpu_req),
    .rsp (fpu_rsp)
  );

  // Where the program goes once the current step is written back.
  always_comb begin
    adv_pc    = pc + 5'd1;
    adv_idx   = idx;
    adv_state = S_ISSUE;
    case (pc)
      PC_P1_END: begin
        adv_idx = idx + CW'(1);
        if (idx + CW'(1) == n_reg) begin
          adv_pc = PC_MEAN;
        end else begin
          adv_pc    = PC_P1_START;
          adv_state = S_READ;
        end
      end
      PC_MEAN: begin
        adv_idx   = '0;
        adv_state = S_READ;
      end
      PC_P2_END: begin
        adv_idx = idx + CW'(1);
        if (idx + CW'(1) == n_reg) begin
          adv_pc = PC_FIN;
        end else begin
          adv_pc    = PC_P2_START;
          adv_state = S_READ;
        end
      end
      PC_LAST: begin
        adv_pc    = pc;
        adv_state = S_DONE;
      end
      default: ;
    endcase
  end

  // Sample memory: written while loading, read one entry per pass step.
  always_ff @(posedge clk) begin
    if (accept && room) begin
      mem[count[AW-1:0]] <= sample.sample_bits;
    end
    rdata <= mem[idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      count        <= '0;
      ovf          <= 1'b0;
      n_reg        <= '0;
      drop_reg     <= 1'b0;
      idx          <= '0;
      pc           <= PC_P1_START;
      result_valid <= 1'b0;
    end else begin
      // In the done state the output register is reloaded instead.
      if (result_valid && result_ready && state != S_DONE) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (accept) begin
            if (sample.is_last) begin
              n_reg    <= count_next;
              drop_reg <= ovf_next;
              count    <= '0;
              ovf      <= 1'b0;
              idx      <= '0;
              pc       <= PC_P1_START;
              r_hi     <= '0;
              r_lo     <= '0;
              r_s      <= '0;
              r_sl     <= '0;
              r_sq     <= '0;
              r_sql    <= '0;
              r_nd     <= int_to_dbl(32'(count_next));
              r_nm1    <= int_to_dbl(32'(count_next) - 32'd1);
              if (count_next < CW'(2)) begin
                // Fewer than two samples give positive zero.
                r_a   <= '0;
                state <= S_DONE;
              end else begin
                state <= S_READ;
              end
            end else begin
              count <= count_next;
              ovf   <= ovf_next;
            end
          end
        end
        S_READ: begin
          state <= S_CAPTURE;
        end
        S_CAPTURE: begin
          r_x   <= rdata;
          state <= S_ISSUE;
        end
        S_ISSUE, S_WAIT: begin
          if (state == S_ISSUE ? (u.op == csd_pkg::OP_MOV) : fpu_rsp.done) begin
            case (u.dst)
              R_X:     r_x    <= wb_data;
              R_HI:    r_hi   <= wb_data;
              R_LO:    r_lo   <= wb_data;
              R_A:     r_a    <= wb_data;
              R_T:     r_t    <= wb_data;
              R_TMP:   r_tmp  <= wb_data;
              R_MEAN:  r_mean <= wb_data;
              R_S:     r_s    <= wb_data;
              R_SL:    r_sl   <= wb_data;
              R_SQ:    r_sq   <= wb_data;
              R_SQL:   r_sql  <= wb_data;
              R_DIFF:  r_diff <= wb_data;
              R_ND:    r_nd   <= wb_data;
              R_NM1:   r_nm1  <= wb_data;
              default: r_a    <= wb_data;
            endcase
            pc    <= adv_pc;
            idx   <= adv_idx;
            state <= adv_state;
          end else if (state == S_ISSUE) begin
            state <= S_WAIT;
          end
        end
        S_DONE: begin
          // The output register frees as soon as the previous word is taken.
          if (!result_valid || result_ready) begin
            result_valid <= 1'b1;
            result       <= '{deviation_bits: r_a, dropped: drop_reg};
            state        <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_SAMPLES))
    else $error("sample count exceeds the store depth");

  a_done_expected: assert property (@(posedge clk) disable iff (rst)
    fpu_rsp.done |-> state == S_WAIT)
    else $error("arithmetic unit finished while no step was waiting");

  a_read_in_set: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |-> idx < n_reg)
    else $error("pass reads beyond the stored set");
`endif

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// Testbench for the compensated standard deviation block.
// Sample words come from a queue that an initial block fills with sets of samples.
// A clocked driver offers them with random gaps.
// A clocked monitor takes result words with random stalls.
// Every accepted word marked last goes through a local model of the block:
// the two compensated passes use real arithmetic and the root is taken on the
// bit pattern. The expected result is queued and checked field by field.
module tb_top;

  localparam int DEPTH       = csd_pkg::MAX_SAMPLES_DEF;
  localparam int STALL_LIMIT = 1000000;
  localparam int QUIET_TAIL  = 150;

  typedef struct {
    csd_pkg::sample_t word;
    bit               drain_first;
  } pending_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             sample_valid = 1'b0;
  logic             sample_ready;
  csd_pkg::sample_t sample = '0;
  logic             result_valid;
  logic             result_ready = 1'b0;
  csd_pkg::result_t result;

  pending_t         pending_q[$];
  csd_pkg::result_t deviation_q[$];

  // Local copy of the block state.
  logic [63:0] set_store[DEPTH];
  int          set_count = 0;
  bit          set_dropped = 1'b0;

  int  errors = 0;
  int  results_seen = 0;
  int  idle_cycles = 0;
  int  send_gap = 0;
  int  recv_gap = 0;
  int  hold_cycles = 0;
  bit  hold_done = 1'b0;
  bit  quiet;

  compensated_std_deviation u_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Exactly rounded square root on a double bit pattern. The integer root of
  // the radicand of up to 108 bits yields 54 bits, the last of which rounds the result.
  function automatic logic [63:0] root_of(logic [63:0] x);
    logic [10:0]  ef;
    logic [51:0]  frac;
    logic [63:0]  m;
    logic [127:0] rad;
    logic [127:0] rem;
    logic [127:0] trial;
    logic [63:0]  q;
    int           e;
    int           big;
    ef   = x[62:52];
    frac = x[51:0];
    if (ef == 11'h7FF) begin
      if (frac != 0) return x | csd_pkg::QUIET_BIT;
      if (x[63]) return csd_pkg::DEFAULT_NAN;
      return x;
    end
    if (x[62:0] == 0) return x;
    if (x[63]) return csd_pkg::DEFAULT_NAN;
    if (ef == 0) begin
      m = {12'd0, frac};
      e = -1074;
      while (m < (64'd1 << 52)) begin
        m = m << 1;
        e--;
      end
    end else begin
      m = {11'd1, frac};
      e = int'(ef) - 1075;
    end
    if (e % 2 != 0) begin
      m = m << 1;
      e--;
    end
    rad = {64'd0, m} << 54;
    rem = '0;
    q   = '0;
    for (int i = 63; i >= 0; i--) begin
      rem   = (rem << 2) | ((rad >> (2 * i)) & 128'd3);
      trial = ({64'd0, q} << 2) | 128'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        q   = (q << 1) | 64'd1;
      end else begin
        q = q << 1;
      end
    end
    q   = (q >> 1) + {63'd0, q[0]};
    big = (e - 54) / 2 + 1;
    if (q == (64'd1 << 53)) begin
      q = q >> 1;
      big++;
    end
    return {1'b0, 11'(big + 52 + 1023), q[51:0]};
  endfunction

  // Mean from a Kahan sum, then compensated sums of deviations and squares.
  function automatic logic [63:0] set_deviation(int n);
    real hi, lo, mean, nd, s, s_lo, sq, sq_lo, a, t, diff, prod, var_est;
    hi = 0.0; lo = 0.0; s = 0.0; s_lo = 0.0; sq = 0.0; sq_lo = 0.0;
    if (n < 2) return 64'd0;
    nd = real'(n);
    for (int i = 0; i < n; i++) begin
      a  = $bitstoreal(set_store[i]) + lo;
      t  = hi + a;
      lo = a - (t - hi);
      hi = t;
    end
    mean = hi / nd;
    for (int i = 0; i < n; i++) begin
      diff = $bitstoreal(set_store[i]) - mean;
      a    = diff + s_lo;
      t    = s + a;
      s_lo = a - (t - s);
      s    = t;
      prod  = diff * diff;
      a     = prod + sq_lo;
      t     = sq + a;
      sq_lo = a - (t - sq);
      sq    = t;
    end
    var_est = (sq - (s * s) / nd) / real'(n - 1);
    return root_of($realtobits(var_est));
  endfunction

  // Store one accepted sample; a word marked last closes the set and queues
  // its expected result.
  function automatic void take_sample(csd_pkg::sample_t w);
    csd_pkg::result_t r;
    if (set_count < DEPTH) begin
      set_store[set_count] = w.sample_bits;
      set_count++;
    end else begin
      set_dropped = 1'b1;
    end
    if (w.is_last) begin
      r.deviation_bits = set_deviation(set_count);
      r.dropped        = set_dropped;
      deviation_q.push_back(r);
      set_count   = 0;
      set_dropped = 1'b0;
    end
  endfunction

  // Sample values: mostly normal numbers of similar size so that the passes do
  // real work, with specials, subnormals, huge values and raw patterns mixed in.
  function automatic logic [63:0] pick_value();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 11))
      0, 1, 2, 3, 4, 5: v[62:52] = 11'(1023 + $urandom_range(0, 12) - 6);
      6: v[62:52] = 11'(1023 + $urandom_range(0, 80) - 40);
      7: ;
      8: v[62:52] = 11'd0;
      9: v[62:52] = 11'(2046 - $urandom_range(0, 3));
      10: v[62:52] = 11'h7FF;
      default: v = $urandom_range(0, 1) ? 64'd0 : 64'h8000_0000_0000_0000;
    endcase
    return v;
  endfunction

  function automatic void queue_set(logic [63:0] vals[$], bit drain);
    pending_t p;
    foreach (vals[i]) begin
      p.word.sample_bits = vals[i];
      p.word.is_last     = (i == vals.size() - 1);
      p.drain_first      = drain && (i == 0);
      pending_q.push_back(p);
    end
  endfunction

  initial begin
    logic [63:0] vals[$];
    int          len;

    // Directed sets: single sample, equal pair, extremes and specials.
    queue_set('{64'h3FF0_0000_0000_0000}, 1'b0);
    queue_set('{64'h4000_0000_0000_0000, 64'h4000_0000_0000_0000}, 1'b0);
    queue_set('{64'd0, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b0);
    queue_set('{64'h7FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000}, 1'b0);
    queue_set('{64'hFFF0_0000_0000_0000, 64'h3FF0_0000_0000_0000}, 1'b0);
    queue_set('{64'h7FF0_0000_0000_0001, 64'h4008_0000_0000_0000}, 1'b0);
    queue_set('{64'h7FEF_FFFF_FFFF_FFFF, 64'hFFEF_FFFF_FFFF_FFFF}, 1'b0);
    queue_set('{64'h0000_0000_0000_0001, 64'h000F_FFFF_FFFF_FFFF,
                64'h8000_0000_0000_0003}, 1'b0);
    queue_set('{64'h3FF0_0000_0000_0000, 64'h4000_0000_0000_0000,
                64'h4008_0000_0000_0000, 64'h4010_0000_0000_0000}, 1'b1);

    // One set that overruns the store; its last sample is dropped too.
    vals = {};
    for (int i = 0; i < DEPTH + 2; i++) vals.push_back(pick_value());
    queue_set(vals, 1'b1);

    // Random small sets; now and then the sender waits for all results first.
    for (int k = 0; k < 130; k++) begin
      vals = {};
      len  = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 9);
      for (int i = 0; i < len; i++) vals.push_back(pick_value());
      queue_set(vals, $urandom_range(0, 29) == 0);
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  assign quiet = pending_q.size() < QUIET_TAIL;

  // Sender. The next valid is worked out first and assigned once per edge.
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      if (sample_valid && sample_ready) take_sample(sample);
      if (sample_valid && !sample_ready) begin
        sample_valid <= 1'b1;
      end else if (send_gap > 0) begin
        send_gap--;
        sample_valid <= 1'b0;
      end else if (pending_q.size() > 0 &&
                   (!pending_q[0].drain_first || deviation_q.size() == 0)) begin
        sample       <= pending_q[0].word;
        sample_valid <= 1'b1;
        void'(pending_q.pop_front());
        if (!quiet && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 13);
      end else begin
        sample_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off once a few results are in,
  // so that a second result backs up and the block stops taking samples.
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        results_seen++;
        if (deviation_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result word %h / %0d",
                                     result.deviation_bits, result.dropped);
        end else begin
          if (result.deviation_bits !== deviation_q[0].deviation_bits ||
              result.dropped !== deviation_q[0].dropped) begin
            errors++;
            if (errors <= 10)
              $display("result %0d: expected %h / %0d, got %h / %0d", results_seen,
                       deviation_q[0].deviation_bits, deviation_q[0].dropped,
                       result.deviation_bits, result.dropped);
          end
          void'(deviation_q.pop_front());
        end
      end
      if (!hold_done && results_seen == 15) begin
        hold_done   = 1'b1;
        hold_cycles = 3000;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        result_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) recv_gap = $urandom_range(1, 13);
      end
    end
  end

  // Watchdog on cycles without any accepted word; the longest legal gap is
  // a full store being computed, well under the limit.
  always @(posedge clk) begin
    if (!rst) begin
      if ((sample_valid && sample_ready) || (result_valid && result_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    wait (!rst);
    wait (pending_q.size() == 0 && !sample_valid && deviation_q.size() == 0);
    repeat (400) @(posedge clk);
    if (errors == 0 && deviation_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* files.f */
sv/csd_pkg.sv
sv/csd_fpu.sv
sv/compensated_std_deviation.sv
dv/tb_top.sv
